### design/assert_macros.svh
// assertion helpers, disabled by ASSERT_OFF
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property held at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, rst, expr)

`endif

`endif

### design/bsl_pkg.sv
package bsl_pkg;

   localparam int DEPTH  = 16;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int VAL_W  = 32;
   localparam int KIND_W = 3;
   localparam int POS_W  = 5;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 5;
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_INS_FRONT = 3'd0,
      KIND_INS_BACK  = 3'd1,
      KIND_INS_AT    = 3'd2,
      KIND_DEL_FRONT = 3'd3,
      KIND_DEL_BACK  = 3'd4,
      KIND_DEL_AT    = 3'd5,
      KIND_SEARCH    = 3'd6,
      KIND_DUMP      = 3'd7
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_EMPTY   = 2'd2,
      STATUS_INVALID = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_SHIFT_BACK = 2'd1,
      CELL_SHIFT_FWD  = 2'd2,
      CELL_LOAD       = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [VAL_W-1:0]  data;
   } cell_ctl_type;

endpackage

### design/bsl_cell.sv
module bsl_cell
   import bsl_pkg::*;
(
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [VAL_W-1:0]   prev_value,
   input  logic [VAL_W-1:0]   next_value,
   output logic [VAL_W-1:0]   value,
   output logic               match
);

   logic [VAL_W-1:0] value_ff;

   always_ff @(posedge clock) begin
      unique case (ctl.op)
         CELL_HOLD:       value_ff <= value_ff;
         CELL_SHIFT_BACK: value_ff <= prev_value;
         CELL_SHIFT_FWD:  value_ff <= next_value;
         CELL_LOAD:       value_ff <= ctl.data;
         default:         value_ff <= value_ff;
      endcase
   end

   assign value = value_ff;
   assign match = (value_ff == ctl.data);

endmodule

### design/bounded_sequence_list_core.sv
// channel   | ports                                         | handshake
// ----------+-----------------------------------------------+---------------------------
// request   | req_kind, req_value, req_position             | start high while busy low
// response  | rsp_status, rsp_found, rsp_entry,             | rsp_valid, one cycle a beat
//           | rsp_occupancy, rsp_last                       |
//
// inserts, deletes and searches are each handled in the accepting cycle and may follow
// back to back; the response beat appears the cycle after acceptance
// a dump rotates the row once through the occupied cells: one beat per entry,
// busy while the dump state sends the entries out
// reset clears the entry count and the control state; cell contents are not cleared
// the response side cannot stall: every beat is taken in its cycle
module bounded_sequence_list_core
   import bsl_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [KIND_W-1:0]         req_kind,
   input  logic signed [VAL_W-1:0]   req_value,
   input  logic [POS_W-1:0]          req_position,
   output logic                      rsp_valid,
   output logic [STAT_W-1:0]         rsp_status,
   output logic                      rsp_found,
   output logic signed [VAL_W-1:0]   rsp_entry,
   output logic [OCC_W-1:0]          rsp_occupancy,
   output logic                      rsp_last
);

`include "assert_macros.svh"

   typedef enum logic {
      SM_IDLE,
      SM_DUMP
   } sm_type;

   sm_type               state_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic [CNT_W-1:0]     left_ff;
   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   status_type           status_in;
   logic                 rsp_found_ff;
   logic [VAL_W-1:0]     rsp_entry_ff;
   logic [OCC_W-1:0]     rsp_occupancy_ff;
   logic                 rsp_last_ff;

   kind_type             kind;
   logic                 go;
   logic                 dumping;
   logic                 is_ins;
   logic                 is_del;
   logic                 full;
   logic                 del_ok;
   logic                 hit_any;
   logic [CMP_W-1:0]     count_w;
   logic [CMP_W-1:0]     pos_w;
   logic [CMP_W-1:0]     pos_m1;
   logic [CMP_W-1:0]     ins_idx;
   logic [CMP_W-1:0]     del_idx;
   logic [VAL_W-1:0]     bus_data;

   logic [VAL_W-1:0]     values [DEPTH];
   logic [DEPTH-1:0]     match;
   logic [DEPTH-1:0]     hit;
   cell_ctl_type         ctl [DEPTH];

   assign kind    = kind_type'(req_kind);
   assign dumping = (state_ff == SM_DUMP);
   assign busy    = dumping;
   assign go      = start && !dumping;
   assign is_ins  = (kind == KIND_INS_FRONT) || (kind == KIND_INS_BACK) ||
                    (kind == KIND_INS_AT);
   assign is_del  = (kind == KIND_DEL_FRONT) || (kind == KIND_DEL_BACK) ||
                    (kind == KIND_DEL_AT);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign count_w = CMP_W'(count_ff);
   assign pos_w   = CMP_W'(req_position);
   assign pos_m1  = pos_w - CMP_W'(1);
   assign bus_data = dumping ? values[0] : req_value;
   assign hit_any = |hit;

   always_comb begin
      unique case (kind)
         KIND_INS_FRONT: ins_idx = '0;
         KIND_INS_BACK:  ins_idx = count_w;
         default: begin
            if (pos_w == '0) begin
               ins_idx = '0;
            end else if (pos_m1 > count_w) begin
               ins_idx = count_w;
            end else begin
               ins_idx = pos_m1;
            end
         end
      endcase
   end

   always_comb begin
      unique case (kind)
         KIND_DEL_FRONT: del_idx = '0;
         KIND_DEL_BACK:  del_idx = count_w - CMP_W'(1);
         default:        del_idx = pos_m1;
      endcase
   end

   assign del_ok = (count_ff != '0) &&
                   !((kind == KIND_DEL_AT) && ((pos_w == '0) || (pos_m1 >= count_w)));

   // the row of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VAL_W-1:0] prev_v;
      logic [VAL_W-1:0] next_v;

      if (i == 0) begin : g_first
         assign prev_v = values[i];
      end else begin : g_mid_prev
         assign prev_v = values[i-1];
      end

      if (i == DEPTH - 1) begin : g_end
         assign next_v = values[i];
      end else begin : g_mid_next
         assign next_v = values[i+1];
      end

      always_comb begin
         ctl[i].data = bus_data;
         ctl[i].op   = CELL_HOLD;
         if (dumping) begin
            // rotate the occupied cells, front value wraps to the back
            if (CMP_W'(i) == count_w - CMP_W'(1)) begin
               ctl[i].op = CELL_LOAD;
            end else if (CMP_W'(i) < count_w - CMP_W'(1)) begin
               ctl[i].op = CELL_SHIFT_FWD;
            end
         end else if (go && is_ins && !full) begin
            if (CMP_W'(i) == ins_idx) begin
               ctl[i].op = CELL_LOAD;
            end else if (CMP_W'(i) > ins_idx) begin
               ctl[i].op = CELL_SHIFT_BACK;
            end
         end else if (go && is_del && del_ok) begin
            if (CMP_W'(i) >= del_idx) begin
               ctl[i].op = CELL_SHIFT_FWD;
            end
         end
      end

      assign hit[i] = match[i] && (CMP_W'(i) < count_w);

      bsl_cell u_cell (
         .clock      (clock),
         .ctl        (ctl[i]),
         .prev_value (prev_v),
         .next_value (next_v),
         .value      (values[i]),
         .match      (match[i])
      );
   end

   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_OK;
      if (is_ins) begin
         if (full) begin
            status_in = STATUS_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else if (is_del) begin
         if (count_ff == '0) begin
            status_in = STATUS_EMPTY;
         end else if (!del_ok) begin
            status_in = STATUS_INVALID;
         end else begin
            count_in = count_ff - CNT_W'(1);
         end
      end else if (kind == KIND_DUMP) begin
         if (count_ff == '0) begin
            status_in = STATUS_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SM_IDLE;
         count_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            SM_IDLE: begin
               if (go) begin
                  rsp_status_ff    <= status_in;
                  rsp_found_ff     <= (kind == KIND_SEARCH) && hit_any;
                  rsp_entry_ff     <= '0;
                  rsp_occupancy_ff <= OCC_W'(count_in);
                  rsp_last_ff      <= 1'b1;
                  count_ff         <= count_in;
                  if ((kind == KIND_DUMP) && (count_ff != '0)) begin
                     state_ff <= SM_DUMP;
                     left_ff  <= count_ff;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            SM_DUMP: begin
               rsp_valid_ff     <= 1'b1;
               rsp_status_ff    <= STATUS_OK;
               rsp_found_ff     <= 1'b0;
               rsp_entry_ff     <= values[0];
               rsp_occupancy_ff <= OCC_W'(count_ff);
               rsp_last_ff      <= (left_ff == CNT_W'(1));
               left_ff          <= left_ff - CNT_W'(1);
               if (left_ff == CNT_W'(1)) begin
                  state_ff <= SM_IDLE;
               end
            end
            default: state_ff <= SM_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_entry     = rsp_entry_ff;
   assign rsp_occupancy = rsp_occupancy_ff;
   assign rsp_last      = rsp_last_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `ASSERT_PROP(a_dump_beat, clock, reset, dumping |=> rsp_valid)
   `ASSERT_PROP(a_dump_count, clock, reset, dumping |=> count_ff == $past(count_ff))
   `ASSERT_PROP(a_single_beat, clock, reset,
      (go && (kind != KIND_DUMP)) |=> (rsp_valid && rsp_last))

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import bsl_pkg::*;

   typedef struct {
      status_type       status;
      logic             found;
      logic [VAL_W-1:0] entry;
      logic [OCC_W-1:0] occupancy;
      logic             last;
   } beat_type;

   typedef struct {
      kind_type         kind;
      logic [VAL_W-1:0] value;
      logic [POS_W-1:0] position;
      int               reps;
      bit               typed;
      status_type       status;
      bit               found;
      logic [OCC_W-1:0] occupancy;
   } script_row_type;

   localparam int SCRIPT_LEN = 26;
   localparam int RANDOM_PER_PHASE = 77;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [KIND_W-1:0]       req_kind;
   logic signed [VAL_W-1:0] req_value;
   logic [POS_W-1:0]        req_position;
   logic                    rsp_valid;
   logic [STAT_W-1:0]       rsp_status;
   logic                    rsp_found;
   logic signed [VAL_W-1:0] rsp_entry;
   logic [OCC_W-1:0]        rsp_occupancy;
   logic                    rsp_last;

   logic [VAL_W-1:0] shadow_cells [DEPTH];
   int               shadow_count;
   beat_type         pending_beats [$];
   beat_type         want_beat;
   script_row_type   script [SCRIPT_LEN];
   int               mismatches;
   int               beat_no;
   int               idle_pct;
   bit               filling;

   bounded_sequence_list_core dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_value     (req_value),
      .req_position  (req_position),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_found     (rsp_found),
      .rsp_entry     (rsp_entry),
      .rsp_occupancy (rsp_occupancy),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                  input logic [VAL_W-1:0] want);
      mismatches++;
      if (mismatches <= 40)
         $display("%0t beat %0d: %s got %h want %h", $time, beat_no, what, got, want);
   endtask

   // list behaviour: packed cells, front at index 0
   task automatic apply_list_op(input kind_type k, input logic [VAL_W-1:0] v,
                                input logic [POS_W-1:0] p);
      status_type st;
      logic       hit;
      int         idx;
      int         i;
      beat_type   b;
      st  = STATUS_OK;
      hit = 1'b0;
      case (k)
         KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT: begin
            if (shadow_count >= DEPTH) begin
               st = STATUS_FULL;
            end else begin
               if (k == KIND_INS_FRONT) idx = 0;
               else if (k == KIND_INS_BACK) idx = shadow_count;
               else idx = (p == 0) ? 0 : int'(p) - 1;
               if (idx > shadow_count) idx = shadow_count;
               for (i = shadow_count; i > idx; i--) shadow_cells[i] = shadow_cells[i-1];
               shadow_cells[idx] = v;
               shadow_count++;
            end
         end
         KIND_DEL_FRONT, KIND_DEL_BACK, KIND_DEL_AT: begin
            if (shadow_count == 0) begin
               st = STATUS_EMPTY;
            end else begin
               if (k == KIND_DEL_FRONT) idx = 0;
               else if (k == KIND_DEL_BACK) idx = shadow_count - 1;
               else idx = int'(p) - 1;
               if (idx < 0 || idx >= shadow_count) begin
                  st = STATUS_INVALID;
               end else begin
                  for (i = idx; i < shadow_count - 1; i++) shadow_cells[i] = shadow_cells[i+1];
                  shadow_count--;
               end
            end
         end
         KIND_SEARCH: begin
            for (i = 0; i < shadow_count; i++)
               if (shadow_cells[i] == v) hit = 1'b1;
         end
         default: begin
            if (shadow_count == 0) begin
               st = STATUS_EMPTY;
            end else begin
               for (i = 0; i < shadow_count; i++) begin
                  b.status    = STATUS_OK;
                  b.found     = 1'b0;
                  b.entry     = shadow_cells[i];
                  b.occupancy = OCC_W'(shadow_count);
                  b.last      = (i == shadow_count - 1);
                  pending_beats.push_back(b);
               end
               return;
            end
         end
      endcase
      b.status    = st;
      b.found     = hit;
      b.entry     = '0;
      b.occupancy = OCC_W'(shadow_count);
      b.last      = 1'b1;
      pending_beats.push_back(b);
   endtask

   task automatic issue(input kind_type k, input logic [VAL_W-1:0] v,
                        input logic [POS_W-1:0] p, input bit typed, input beat_type typed_beat);
      int held;
      req_kind     <= k;
      req_value    <= v;
      req_position <= p;
      start        <= 1'b1;
      do @(posedge clock); while (busy);
      held = pending_beats.size();
      apply_list_op(k, v, p);
      if (typed) begin
         while (pending_beats.size() > held) void'(pending_beats.pop_back());
         pending_beats.push_back(typed_beat);
      end
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(3))
         0: return $urandom;
         1: return VAL_W'($urandom_range(15)) - VAL_W'(8);
         2: begin
            case ($urandom_range(3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         default: begin
            if (shadow_count > 0) return shadow_cells[$urandom_range(shadow_count - 1)];
            return $urandom;
         end
      endcase
   endfunction

   // fill and drain bursts so that both full and empty lists come up often
   task automatic pick_item(output kind_type k, output logic [VAL_W-1:0] v,
                            output logic [POS_W-1:0] p);
      int r;
      if (shadow_count >= DEPTH) filling = 1'b0;
      if (shadow_count == 0) filling = 1'b1;
      if ($urandom_range(19) == 0) filling = !filling;
      r = $urandom_range(99);
      if (r < 8) k = KIND_DUMP;
      else if (r < 20) k = KIND_SEARCH;
      else if (r < (filling ? 75 : 40)) k = kind_type'(KIND_W'($urandom_range(2)));
      else k = kind_type'(KIND_W'(3 + $urandom_range(2)));
      v = pick_value();
      if ($urandom_range(3) == 0) p = POS_W'($urandom_range(31));
      else p = POS_W'($urandom_range(shadow_count + 1));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_beats.size() == 0) begin
            report_mismatch("beat with nothing pending, entry", rsp_entry, '0);
         end else begin
            want_beat = pending_beats.pop_front();
            if (rsp_status !== want_beat.status)
               report_mismatch("status", VAL_W'(rsp_status), VAL_W'(want_beat.status));
            if (rsp_found !== want_beat.found)
               report_mismatch("found", VAL_W'(rsp_found), VAL_W'(want_beat.found));
            if (rsp_entry !== want_beat.entry)
               report_mismatch("entry", rsp_entry, want_beat.entry);
            if (rsp_occupancy !== want_beat.occupancy)
               report_mismatch("occupancy", VAL_W'(rsp_occupancy),
                               VAL_W'(want_beat.occupancy));
            if (rsp_last !== want_beat.last)
               report_mismatch("last", VAL_W'(rsp_last), VAL_W'(want_beat.last));
         end
         beat_no++;
      end
   end

   initial begin
      script_row_type   row;
      beat_type         typed_beat;
      kind_type         k;
      logic [VAL_W-1:0] v;
      logic [POS_W-1:0] p;
      int               phase_pct [3];
      int               settle;
      reset        <= 1'b1;
      start        <= 1'b0;
      req_kind     <= '0;
      req_value    <= '0;
      req_position <= '0;
      shadow_count = 0;
      mismatches   = 0;
      beat_no      = 0;
      idle_pct     = 0;
      filling      = 1'b1;
      phase_pct    = '{0, 78, 17};
      script = '{
         '{KIND_DUMP,      32'h0000_0000, 5'd0,  1,  1'b1, STATUS_EMPTY,   1'b0, 5'd0},
         '{KIND_DEL_FRONT, 32'h0000_0000, 5'd0,  1,  1'b1, STATUS_EMPTY,   1'b0, 5'd0},
         '{KIND_DEL_BACK,  32'h0000_0000, 5'd0,  1,  1'b1, STATUS_EMPTY,   1'b0, 5'd0},
         '{KIND_DEL_AT,    32'h0000_0000, 5'd0,  1,  1'b1, STATUS_EMPTY,   1'b0, 5'd0},
         '{KIND_SEARCH,    32'h0000_0000, 5'd0,  1,  1'b1, STATUS_OK,      1'b0, 5'd0},
         '{KIND_INS_FRONT, 32'h7fff_ffff, 5'd0,  1,  1'b1, STATUS_OK,      1'b0, 5'd1},
         '{KIND_INS_BACK,  32'h8000_0000, 5'd0,  1,  1'b1, STATUS_OK,      1'b0, 5'd2},
         '{KIND_INS_AT,    32'hffff_ffff, 5'd0,  1,  1'b1, STATUS_OK,      1'b0, 5'd3},
         '{KIND_INS_AT,    32'h0000_0000, 5'd31, 1,  1'b1, STATUS_OK,      1'b0, 5'd4},
         '{KIND_INS_AT,    32'h0000_0005, 5'd2,  1,  1'b1, STATUS_OK,      1'b0, 5'd5},
         '{KIND_DUMP,      32'h0000_0000, 5'd0,  1,  1'b0, STATUS_OK,      1'b0, 5'd0},
         '{KIND_SEARCH,    32'h8000_0000, 5'd0,  1,  1'b1, STATUS_OK,      1'b1, 5'd5},
         '{KIND_DEL_AT,    32'h0000_0000, 5'd0,  1,  1'b1, STATUS_INVALID, 1'b0, 5'd5},
         '{KIND_DEL_AT,    32'h0000_0000, 5'd6,  1,  1'b1, STATUS_INVALID, 1'b0, 5'd5},
         '{KIND_DEL_AT,    32'h0000_0000, 5'd3,  1,  1'b1, STATUS_OK,      1'b0, 5'd4},
         '{KIND_DEL_FRONT, 32'h0000_0000, 5'd0,  1,  1'b1, STATUS_OK,      1'b0, 5'd3},
         '{KIND_DEL_BACK,  32'h0000_0000, 5'd0,  1,  1'b1, STATUS_OK,      1'b0, 5'd2},
         '{KIND_DUMP,      32'h0000_0000, 5'd0,  1,  1'b0, STATUS_OK,      1'b0, 5'd0},
         '{KIND_INS_BACK,  32'h5a5a_a5a5, 5'd0,  14, 1'b0, STATUS_OK,      1'b0, 5'd0},
         '{KIND_INS_FRONT, 32'h0000_0001, 5'd0,  1,  1'b1, STATUS_FULL,    1'b0, 5'd16},
         '{KIND_INS_AT,    32'h0000_0002, 5'd5,  1,  1'b1, STATUS_FULL,    1'b0, 5'd16},
         '{KIND_INS_BACK,  32'h0000_0003, 5'd0,  1,  1'b1, STATUS_FULL,    1'b0, 5'd16},
         '{KIND_DUMP,      32'h0000_0000, 5'd0,  1,  1'b0, STATUS_OK,      1'b0, 5'd0},
         '{KIND_DEL_AT,    32'h0000_0000, 5'd16, 1,  1'b1, STATUS_OK,      1'b0, 5'd15},
         '{KIND_DEL_AT,    32'h0000_0000, 5'd16, 1,  1'b1, STATUS_INVALID, 1'b0, 5'd15},
         '{KIND_SEARCH,    32'h5a5a_a5a5, 5'd0,  1,  1'b0, STATUS_OK,      1'b0, 5'd0}
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[r]) begin
         row = script[r];
         typed_beat.status    = row.status;
         typed_beat.found     = row.found;
         typed_beat.entry     = '0;
         typed_beat.occupancy = row.occupancy;
         typed_beat.last      = 1'b1;
         repeat (row.reps) issue(row.kind, row.value, row.position, row.typed, typed_beat);
      end

      foreach (phase_pct[ph]) begin
         idle_pct = phase_pct[ph];
         repeat (RANDOM_PER_PHASE) begin
            pick_item(k, v, p);
            issue(k, v, p, 1'b0, typed_beat);
         end
      end
      start <= 1'b0;

      settle = 0;
      while (pending_beats.size() != 0 && settle < 1000) begin
         @(posedge clock);
         settle++;
      end
      repeat (DEPTH + 4) @(posedge clock);
      if (pending_beats.size() != 0)
         report_mismatch("beats never seen", pending_beats.size(), '0);

      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/bsl_pkg.sv
design/bsl_cell.sv
design/bounded_sequence_list_core.sv
verif/tb.sv
